// File: hdl/aes128_block_encrypt_macros.svh
// Assertion macros shared by the encryption block
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH
// Clocked assertion with asynchronous active-low reset
`define AES_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Clocked next-cycle implication with asynchronous active-low reset
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/aes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg
// Types, constants and round functions for the AES-128 block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockBytes = 16;
  localparam logic [7:0] GfPoly = 8'h1B;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] Rcon [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_KEY_UPPER = 1'b0,
    CFG_KEY_LOWER = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 64;

  // State is 128 bits, byte 0 in bits 127:120
  typedef logic [127:0] block_t;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [7:0] get_byte(input block_t s, input int unsigned i);
    get_byte = s[127 - 8*i -: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  // Next round key from the previous one
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t  = sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

  // SubBytes and ShiftRows
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = Sbox[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_cols(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                             a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
    end
    mix_cols = t;
  endfunction

endpackage

// File: hdl/aes_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_in_if / aes_out_if
// Valid/ready channels for plaintext transactions and ciphertext transactions.
// ----------------------------------------------------------------------------
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_upper;
  logic [63:0] plain_lower;
  logic [4:0]  valid_bytes;
  modport source (output valid, plain_upper, plain_lower, valid_bytes, input ready);
  modport sink (input valid, plain_upper, plain_lower, valid_bytes, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_upper;
  logic [63:0] cipher_lower;
  modport source (output valid, cipher_upper, cipher_lower, input ready);
  modport sink (input valid, cipher_upper, cipher_lower, output ready);
endinterface

// File: hdl/aes128_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// AES-128 ECB encryption, fully unrolled pipeline with on-the-fly key schedule.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_if     in   plain_upper, plain_lower, valid_bytes
// out_if    out  cipher_upper, cipher_lower
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (key_upper, key_lower)
//
// One transaction per cycle while the output is not stalled; the stages are padding plus
// initial AddRoundKey, ten round stages and the output register, one round per stage.
// Round keys travel down the pipeline next to the state of each block.
// Reset clears the valid bits and the key registers.
// A stall freezes the whole pipeline; ready is high when the output stage is
// empty or being taken.
module aes128_block_encrypt
  import aes_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  aes_in_if.sink              in_if,
  aes_out_if.source           out_if
);
  `include "aes128_block_encrypt_macros.svh"

  localparam int unsigned Stages = NumRounds + 1;

  logic [63:0] key_upper_q, key_lower_q;
  block_t      state_q [Stages];
  block_t      rkey_q  [Stages];
  logic        vld_q   [Stages];
  block_t      st_d    [Stages];
  block_t      rk_d    [Stages];
  block_t      out_q;
  logic        out_vld_q;
  logic        advance;
  block_t      plain_pad;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q <= '0;
      key_lower_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_UPPER: key_upper_q <= cfg_data_i;
        CFG_KEY_LOWER: key_lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless the output holds a result not taken
  assign advance      = !out_vld_q || out_if.ready;
  assign in_if.ready  = advance;

  // Zero bytes at or past the valid count
  always_comb begin
    plain_pad = {in_if.plain_upper, in_if.plain_lower};
    for (int i = 0; i < BlockBytes; i++) begin
      if (5'(i) >= in_if.valid_bytes) plain_pad[127 - 8*i -: 8] = 8'h00;
    end
  end

  // Stage 0: initial AddRoundKey
  assign rk_d[0] = {key_upper_q, key_lower_q};
  assign st_d[0] = plain_pad ^ {key_upper_q, key_lower_q};

  // Round stages
  for (genvar r = 1; r < Stages; r++) begin : g_round
    block_t ss;
    assign rk_d[r] = next_key(rkey_q[r-1], Rcon[r-1]);
    assign ss      = sub_shift(state_q[r-1]);
    assign st_d[r] = ((r == Stages - 1) ? ss : mix_cols(ss)) ^ rk_d[r];
  end

  // Advance valid bits through the stages and into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < Stages; r++) vld_q[r] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= in_if.valid;
      for (int r = 1; r < Stages; r++) vld_q[r] <= vld_q[r-1];
      out_vld_q <= vld_q[Stages-1];
    end
  end

  // Advance state and round keys; hold them on a stall
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int r = 0; r < Stages; r++) begin
        state_q[r] <= st_d[r];
        rkey_q[r]  <= rk_d[r];
      end
      out_q <= state_q[Stages-1];
    end
  end

  assign out_if.valid        = out_vld_q;
  assign out_if.cipher_upper = out_q[127:64];
  assign out_if.cipher_lower = out_q[63:0];

  `AES_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_vld_q |-> in_if.ready)
  `AES_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, out_vld_q && !out_if.ready,
                   out_vld_q && $stable(out_q))
  `AES_ASSERT_NEXT(a_last_to_out, clk_i, rst_ni, advance && vld_q[Stages-1], out_vld_q)
  `AES_ASSERT_NEXT(a_enter_first, clk_i, rst_ni, in_if.valid && in_if.ready, vld_q[0])

endmodule

// File: bench/tb_aes128_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt
// Self-checking bench for the AES-128 ECB encryption pipeline: directed and
// random plaintext blocks under several keys, with random gaps and stalls on
// both channels, checked against a behavioral cipher in the scoreboard.
// ----------------------------------------------------------------------------

// Behavioral AES-128 cipher and queue of expected ciphertext
class cipher_scoreboard;
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic [127:0] pending_q[$];
  int unsigned errors;

  function new();
    key_hi = '0;
    key_lo = '0;
    errors = 0;
  endfunction

  static function logic [7:0] dbl(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  static function logic [7:0] sb(logic [7:0] x);
    return aes_pkg::Sbox[x];
  endfunction

  // Full encryption of one masked block under the current key
  function logic [127:0] encrypt(logic [127:0] blk);
    logic [7:0] st[16];
    logic [7:0] tmp[16];
    logic [31:0] w[44];
    logic [31:0] t;
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] res;
    w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
    w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sb(t[31:24]), sb(t[23:16]), sb(t[15:8]), sb(t[7:0])}
            ^ {aes_pkg::Rcon[i/4 - 1], 24'h0};
      end
      w[i] = w[i-4] ^ t;
    end
    for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8];
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        // substitute and shift rows
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) tmp[r + 4*c] = sb(st[r + 4*((c + r) % 4)]);
        st = tmp;
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
            st[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
            st[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
            st[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int b = 0; b < 4; b++) st[4*c+b] ^= w[rnd*4 + c][31 - 8*b -: 8];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
    return res;
  endfunction

  // Note one accepted plaintext transaction
  function void note_plain(logic [63:0] pu, logic [63:0] pl, logic [4:0] cnt);
    logic [127:0] blk;
    int unsigned n;
    blk = {pu, pl};
    n = (cnt > 16) ? 16 : cnt;
    for (int i = 0; i < 16; i++) if (i >= n) blk[127 - 8*i -: 8] = 8'h00;
    pending_q.push_back(encrypt(blk));
  endfunction

  // Print one mismatch line and count it
  task report(string msg);
    errors++;
    $display("mismatch %s at %0t", msg, $realtime);
  endtask

  // Check one accepted ciphertext transaction
  task check_cipher(logic [63:0] cu, logic [63:0] cl);
    logic [127:0] exp_blk;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected ciphertext %h%h", cu, cl));
      return;
    end
    exp_blk = pending_q.pop_front();
    if (cu !== exp_blk[127:64])
      report($sformatf("cipher_upper: got %h expected %h", cu, exp_blk[127:64]));
    if (cl !== exp_blk[63:0])
      report($sformatf("cipher_lower: got %h expected %h", cl, exp_blk[63:0]));
  endtask
endclass

module tb_aes128_block_encrypt;
  import aes_pkg::*;

  localparam int unsigned Latency = 12;
  localparam longint unsigned CycleLimit = 200000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  aes_in_if in_if ();
  aes_out_if out_if ();

  aes128_block_encrypt dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  cipher_scoreboard board = new();
  longint unsigned cycle_cnt = 0;
  bit long_hold = 0;
  bit hold_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check every ciphertext transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check_cipher(out_if.cipher_upper, out_if.cipher_lower);
  end

  // Note every plaintext transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      board.note_plain(in_if.plain_upper, in_if.plain_lower, in_if.valid_bytes);
  end

  // Receiver: random stalls, plus one long hold on request
  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_done = 1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  task automatic write_key(cfg_idx_e idx, logic [63:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_KEY_UPPER) board.key_hi = value;
    else board.key_lo = value;
  endtask

  task automatic set_key(logic [63:0] hi, logic [63:0] lo);
    write_key(CFG_KEY_UPPER, hi);
    write_key(CFG_KEY_LOWER, lo);
  endtask

  // Offer one plaintext transaction after an optional idle gap
  task automatic send_block(logic [63:0] pu, logic [63:0] pl, logic [4:0] cnt,
                            bit idle);
    int unsigned gap;
    gap = idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.plain_upper <= pu;
    in_if.plain_lower <= pl;
    in_if.valid_bytes <= cnt;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Drop valid and wait for the pipeline to empty
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned n);
    logic [4:0] cnt;
    bit burst;
    burst = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        0: cnt = 5'd0;
        1: cnt = 5'($urandom_range(17, 31));
        2, 3: cnt = 5'd16;
        default: cnt = 5'($urandom_range(1, 16));
      endcase
      send_block({$urandom, $urandom}, {$urandom, $urandom}, cnt,
                 !burst && ($urandom_range(0, 2) != 0));
    end
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_KEY_UPPER;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.plain_upper = '0;
    in_if.plain_lower = '0;
    in_if.valid_bytes = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key, extremes, saturation and zero count
    send_block('0, '0, 5'd16, 0);
    send_block('1, '1, 5'd16, 0);
    send_block('1, '1, 5'd0, 0);
    send_block('1, '1, 5'd31, 0);
    send_block('1, '1, 5'd17, 0);
    drain();
    // FIPS-197 appendix example key and plaintext, then every count from 1 to 15
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 5'd16, 0);
    for (int i = 1; i <= 15; i++)
      send_block(64'hfedcba9876543210, 64'h0123456789abcdef, 5'(i), 1);
    drain();

    set_key('1, '1);
    random_phase(150);
    drain();
    set_key(64'h8000000000000000, 64'h0000000000000001);
    random_phase(150);
    // Long receiver hold while input keeps coming
    long_hold = 1;
    random_phase(100);
    drain();
    for (int k = 0; k < 4; k++) begin
      set_key({$urandom, $urandom}, {$urandom, $urandom});
      random_phase(120);
      drain();
    end

    if (board.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
